/* rtl/touch_coverage_dead_zones_defines.svh */
// Assertion macros for the checker file of the touch coverage block.
`ifndef TOUCH_COVERAGE_DEAD_ZONES_DEFINES_SVH
`define TOUCH_COVERAGE_DEAD_ZONES_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TCDZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TCDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tcdz_pkg.sv */
// Shared constants, codes, command/status types and offset tables for the coverage map.
`timescale 1ns / 1ps
package tcdz_pkg;

  localparam int CELL_PIXELS_DEF = 40;
  localparam int MAX_COLS_DEF    = 64;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int CFG_W = 12;
  localparam int PT_W  = 13;
  localparam int IDX_W = 6;
  localparam int VIS_W = 16;
  localparam int CLS_W = 2;
  localparam int NB_W  = 4;
  localparam int TOT_W = 13;

  localparam int LIGHT_LIMIT     = 4;
  localparam int DEAD_NEIGHBOURS = 6;
  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  // reciprocal scale of the constant divider
  localparam int DIV_SHIFT = 20;

  // center cell plus eight neighbours
  localparam int SCAN_TAPS = 9;
  localparam int SCAN_W    = 4;

  localparam logic [CLS_W-1:0] CLS_NEVER = 2'd0;
  localparam logic [CLS_W-1:0] CLS_LIGHT = 2'd1;
  localparam logic [CLS_W-1:0] CLS_DENSE = 2'd2;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd1200;

  typedef enum logic [1:0] {
    DIV_WIDTH  = 2'd0,
    DIV_HEIGHT = 2'd1,
    DIV_PX     = 2'd2,
    DIV_PY     = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     clr_wr;
    logic     take;
    div_sel_t div_sel;
    logic     cap_cols;
    logic     cap_rows;
    logic     cap_col;
    logic     cap_row;
    logic     pt_addr;
    logic     pt_write;
    logic     q_geo;
    logic     q_scan;
    logic     q_result;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic scan_last;
    logic out_busy;
  } dp_status_t;

  // column offset of scan step k (two's complement)
  function automatic logic [1:0] nb_dx(input logic [SCAN_W-1:0] k);
    logic [1:0] d;
    case (k)
      4'd1, 4'd4, 4'd6: d = 2'b11;
      4'd3, 4'd5, 4'd8: d = 2'b01;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

  // row offset of scan step k (two's complement)
  function automatic logic [1:0] nb_dy(input logic [SCAN_W-1:0] k);
    logic [1:0] d;
    case (k)
      4'd1, 4'd2, 4'd3: d = 2'b11;
      4'd6, 4'd7, 4'd8: d = 2'b01;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

endpackage

/* rtl/tcdz_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcdz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tcdz_cdiv.sv */
// Divide by the constant cell size: registered reciprocal product, one correction step.
`timescale 1ns / 1ps
module tcdz_cdiv import tcdz_pkg::*; #(
  parameter int CELL_PIXELS = CELL_PIXELS_DEF,
  parameter int DW          = PT_W,
  parameter int QW          = 10
) (
  input  logic          clk,
  input  logic [DW-1:0] dvd,
  output logic [QW-1:0] quo
);

  localparam int RECIP = (2 ** DIV_SHIFT) / CELL_PIXELS;
  localparam int RB    = $clog2(RECIP + 1);
  localparam int PRW   = DW + RB;

  logic [PRW-1:0] prod;
  logic [DW-1:0]  dvd_r;
  logic [QW-1:0]  q_est;
  logic [DW-1:0]  back;
  logic [DW-1:0]  rem;

  always_ff @(posedge clk) begin
    prod  <= PRW'(dvd) * PRW'(RECIP);
    dvd_r <= dvd;
  end

  // estimate is exact or one low
  always_comb begin
    q_est = QW'(prod >> DIV_SHIFT);
    back  = DW'(q_est * CELL_PIXELS);
    rem   = dvd_r - back;
    quo   = (rem >= DW'(CELL_PIXELS)) ? q_est + QW'(1) : q_est;
  end

endmodule

/* rtl/tcdz_ctrl.sv */
// Sequencer: memory clear, point update and nine-cell query scan.
`timescale 1ns / 1ps
module tcdz_ctrl import tcdz_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_DIV_W    = 15'h0004,
    S_DIV_H    = 15'h0008,
    S_DIV_X    = 15'h0010,
    S_DIV_Y    = 15'h0020,
    S_DIV_END  = 15'h0040,
    S_PT_ADDR  = 15'h0080,
    S_PT_READ  = 15'h0100,
    S_PT_WRITE = 15'h0200,
    S_Q_GEO    = 15'h0400,
    S_Q_SCAN   = 15'h0800,
    S_Q_WAIT1  = 15'h1000,
    S_Q_WAIT2  = 15'h2000,
    S_Q_RESULT = 15'h4000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_WIDTH;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_next = S_DIV_W;
      end
      S_DIV_W: begin
        cmd.div_sel = DIV_WIDTH;
        state_next  = S_DIV_H;
      end
      S_DIV_H: begin
        cmd.div_sel  = DIV_HEIGHT;
        cmd.cap_cols = 1'b1;
        state_next   = S_DIV_X;
      end
      S_DIV_X: begin
        cmd.div_sel  = DIV_PX;
        cmd.cap_rows = 1'b1;
        state_next   = st.is_query ? S_Q_GEO : S_DIV_Y;
      end
      S_DIV_Y: begin
        cmd.div_sel = DIV_PY;
        cmd.cap_col = 1'b1;
        state_next  = S_DIV_END;
      end
      S_DIV_END: begin
        cmd.cap_row = 1'b1;
        state_next  = S_PT_ADDR;
      end
      S_PT_ADDR: begin
        cmd.pt_addr = 1'b1;
        state_next  = S_PT_READ;
      end
      S_PT_READ: begin
        state_next = S_PT_WRITE;
      end
      S_PT_WRITE: begin
        cmd.pt_write = 1'b1;
        state_next   = S_IDLE;
      end
      S_Q_GEO: begin
        cmd.q_geo  = 1'b1;
        state_next = S_Q_SCAN;
      end
      S_Q_SCAN: begin
        cmd.q_scan = 1'b1;
        if (st.scan_last) state_next = S_Q_WAIT1;
      end
      S_Q_WAIT1: begin
        state_next = S_Q_WAIT2;
      end
      S_Q_WAIT2: begin
        state_next = S_Q_RESULT;
      end
      S_Q_RESULT: begin
        // hold until the previous result has been taken
        if (!st.out_busy) begin
          cmd.q_result = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/tcdz_dpath.sv */
// Datapath: config registers, grid math, count memory, neighbour scan and result register.
`timescale 1ns / 1ps
module tcdz_dpath import tcdz_pkg::*; #(
  parameter int CELL_PIXELS = CELL_PIXELS_DEF,
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   mode,
  input  logic signed [PT_W-1:0] point_x,
  input  logic signed [PT_W-1:0] point_y,
  input  logic [IDX_W-1:0]       cell_col,
  input  logic [IDX_W-1:0]       cell_row,
  input  dp_cmd_t                cmd,
  output dp_status_t             st,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VIS_W-1:0]       visit_count,
  output logic [CLS_W-1:0]       cover_class,
  output logic [NB_W-1:0]        touched_neighbours,
  output logic                   dead_zone,
  output logic [TOT_W-1:0]       touched_cells,
  output logic [TOT_W-1:0]       grid_cells
);

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int GW    = ((MW > IDX_W) ? MW : IDX_W) + 1;
  localparam int QW    = $clog2((2 ** PT_W - 1) / CELL_PIXELS + 1);
  localparam int LW    = QW + GW;
  localparam int FW    = GW + AW;
  localparam int PW    = CW + RW;

  logic [CFG_W-1:0] screen_width, screen_height;

  logic                   mode_r;
  logic signed [PT_W-1:0] px, py;
  logic [IDX_W-1:0]       qc, qr;

  logic [CW-1:0] cols, pt_col;
  logic [RW-1:0] rows, pt_row;
  logic [PW-1:0] gp;
  logic          in_grid, interior;

  logic [PT_W-1:0] dvd;
  logic [QW-1:0]   quo;

  logic [AW-1:0] addr, addr_next, clr_cnt;
  logic [FW-1:0] addr_full;
  logic [GW-1:0] sc, sr, gc, gr, gcols, grows;
  logic [1:0]    dx, dy;
  logic          in_grid_c, interior_c;

  logic [SCAN_W-1:0] k;
  logic              tag1_v, tag1_f, tag2_v, tag2_f;
  logic [COUNT_BITS-1:0] cnt_v, rdata, inc;
  logic [NB_W-1:0]       nb;
  logic [TOT_W-1:0]      total;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;

  logic [VIS_W+COUNT_BITS-1:0] vis_ext;
  logic [TOT_W+PW-1:0]         gp_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_r <= mode;
      px     <= point_x;
      py     <= point_y;
      qc     <= cell_col;
      qr     <= cell_row;
    end
  end

  // dividends: span is (pixels + cell - 1) / cell, a point is its value with the sign bit cleared / cell
  always_comb begin
    case (cmd.div_sel)
      DIV_WIDTH:  dvd = PT_W'(screen_width) + PT_W'(CELL_PIXELS - 1);
      DIV_HEIGHT: dvd = PT_W'(screen_height) + PT_W'(CELL_PIXELS - 1);
      DIV_PX:     dvd = {1'b0, px[PT_W-2:0]};
      DIV_PY:     dvd = {1'b0, py[PT_W-2:0]};
      default:    dvd = '0;
    endcase
  end

  tcdz_cdiv #(
    .CELL_PIXELS (CELL_PIXELS),
    .DW          (PT_W),
    .QW          (QW)
  ) u_cdiv (
    .clk (clk),
    .dvd (dvd),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_cols) begin
      if (quo == '0) cols <= CW'(1);
      else if (LW'(quo) > LW'(MAX_COLS)) cols <= CW'(MAX_COLS);
      else cols <= CW'(quo);
    end
    if (cmd.cap_rows) begin
      if (quo == '0) rows <= RW'(1);
      else if (LW'(quo) > LW'(MAX_ROWS)) rows <= RW'(MAX_ROWS);
      else rows <= RW'(quo);
    end
    if (cmd.cap_col) begin
      if (px[PT_W-1]) pt_col <= '0;
      else if (LW'(quo) >= LW'(cols)) pt_col <= cols - CW'(1);
      else pt_col <= CW'(quo);
    end
    if (cmd.cap_row) begin
      if (py[PT_W-1]) pt_row <= '0;
      else if (LW'(quo) >= LW'(rows)) pt_row <= rows - RW'(1);
      else pt_row <= RW'(quo);
    end
  end

  always_comb begin
    gc         = GW'(qc);
    gr         = GW'(qr);
    gcols      = GW'(cols);
    grows      = GW'(rows);
    in_grid_c  = (gc < gcols) && (gr < grows);
    interior_c = (gc != '0) && (gr != '0) && (gc + GW'(1) < gcols) && (gr + GW'(1) < grows);
  end

  always_ff @(posedge clk) begin
    if (cmd.q_geo) begin
      in_grid  <= in_grid_c;
      interior <= interior_c;
      gp       <= PW'(cols) * PW'(rows);
    end
  end

  // cell to read: point cell, cell 0 for an out-of-grid query, query center, or a neighbour of an interior center
  always_comb begin
    dx = nb_dx(k);
    dy = nb_dy(k);
    if (cmd.pt_addr) begin
      sc = GW'(pt_col);
      sr = GW'(pt_row);
    end else if (!in_grid) begin
      sc = '0;
      sr = '0;
    end else if (k == '0 || !interior) begin
      sc = gc;
      sr = gr;
    end else begin
      sc = gc + {{(GW-2){dx[1]}}, dx};
      sr = gr + {{(GW-2){dy[1]}}, dy};
    end
    addr_full = FW'(sr) * FW'(MAX_COLS) + FW'(sc);
    addr_next = addr_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_addr || cmd.q_scan) begin
      addr <= addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // two-deep tag line tracks reads through address and data registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k      <= '0;
      tag1_v <= 1'b0;
      tag1_f <= 1'b0;
      tag2_v <= 1'b0;
      tag2_f <= 1'b0;
    end else begin
      if (cmd.q_geo) k <= '0;
      else if (cmd.q_scan) k <= k + SCAN_W'(1);
      tag1_v <= cmd.q_scan;
      tag1_f <= (k == '0);
      tag2_v <= tag1_v;
      tag2_f <= tag1_f;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_geo) begin
      nb <= '0;
    end else if (tag2_v) begin
      if (tag2_f) cnt_v <= in_grid ? rdata : '0;
      else if (interior && rdata != '0) nb <= nb + NB_W'(1);
    end
  end

  assign inc = (rdata == '1) ? rdata : rdata + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.pt_write && rdata == '0 && total != TOTAL_MAX) begin
      total <= total + TOT_W'(1);
    end
  end

  always_comb begin
    ram_we    = cmd.clr_wr || cmd.pt_write;
    ram_waddr = cmd.clr_wr ? clr_cnt : addr;
    ram_wdata = cmd.clr_wr ? '0 : inc;
  end

  tcdz_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  assign vis_ext = {{VIS_W{1'b0}}, cnt_v};
  assign gp_ext  = {{TOT_W{1'b0}}, gp};

  always_ff @(posedge clk) begin
    if (cmd.q_result) begin
      visit_count        <= vis_ext[VIS_W-1:0];
      cover_class        <= (cnt_v > COUNT_BITS'(LIGHT_LIMIT)) ? CLS_DENSE :
                            (cnt_v != '0) ? CLS_LIGHT : CLS_NEVER;
      touched_neighbours <= nb;
      dead_zone          <= interior && (cnt_v == '0) && (nb >= NB_W'(DEAD_NEIGHBOURS));
      touched_cells      <= total;
      grid_cells         <= gp_ext[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.q_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    st.clr_last  = (clr_cnt == AW'(DEPTH - 1));
    st.is_query  = mode_r;
    st.scan_last = (k == SCAN_W'(SCAN_TAPS - 1));
    st.out_busy  = out_valid && !out_ready;
  end

endmodule

/* rtl/touch_coverage_dead_zones.sv */
// Touch coverage map: bins touch points into square cells, answers per-cell dead-zone queries.
// One request at a time. For a point request, grid size and cell index come from one shared
// constant divider (one division per cycle, pipelined over width, height, x and y), then a
// read-modify-write of the count memory (one write port, one read port). A query request
// computes grid size, then makes nine reads of the count memory (center and eight neighbours),
// one per cycle. A finished query result sits in the output register while the next request
// is taken; a query that finishes before that result is taken waits for it. After reset all
// MAX_COLS*MAX_ROWS entries of the count memory (4096 by default) are swept to zero, one
// entry a cycle, before the first request is taken; configuration writes are taken throughout.
`timescale 1ns / 1ps
module touch_coverage_dead_zones import tcdz_pkg::*; #(
  parameter int CELL_PIXELS = CELL_PIXELS_DEF,
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic signed [PT_W-1:0] point_x,
  input  logic signed [PT_W-1:0] point_y,
  input  logic [IDX_W-1:0]       cell_col,
  input  logic [IDX_W-1:0]       cell_row,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VIS_W-1:0]       visit_count,
  output logic [CLS_W-1:0]       cover_class,
  output logic [NB_W-1:0]        touched_neighbours,
  output logic                   dead_zone,
  output logic [TOT_W-1:0]       touched_cells,
  output logic [TOT_W-1:0]       grid_cells
);

  dp_cmd_t    cmd;
  dp_status_t st;

  tcdz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tcdz_dpath #(
    .CELL_PIXELS (CELL_PIXELS),
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mode               (mode),
    .point_x            (point_x),
    .point_y            (point_y),
    .cell_col           (cell_col),
    .cell_row           (cell_row),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .visit_count        (visit_count),
    .cover_class        (cover_class),
    .touched_neighbours (touched_neighbours),
    .dead_zone          (dead_zone),
    .touched_cells      (touched_cells),
    .grid_cells         (grid_cells)
  );

endmodule

/* rtl/tcdz_chk.sv */
// Port-level checker for the coverage map, bound to the top level.
`timescale 1ns / 1ps
`include "touch_coverage_dead_zones_defines.svh"
module tcdz_chk import tcdz_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              mode,
  input logic              out_valid,
  input logic [VIS_W-1:0]  visit_count,
  input logic [CLS_W-1:0]  cover_class,
  input logic [NB_W-1:0]   touched_neighbours,
  input logic              dead_zone
);

  // memory sweep keeps requests out right after reset
  `TCDZ_ASSERT_NOW(a_clear_after_reset, $past(rst), !in_ready, "request taken during clear")

  `TCDZ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "back-to-back request taken")

  `TCDZ_ASSERT_NEXT(a_point_no_result, in_valid && in_ready && !mode && !out_valid, !out_valid, "point request produced a result")

  `TCDZ_ASSERT_NOW(a_dead_is_empty, out_valid && dead_zone, visit_count == '0 && cover_class == CLS_NEVER && touched_neighbours >= NB_W'(DEAD_NEIGHBOURS), "dead zone on a touched or sparse cell")

endmodule

bind touch_coverage_dead_zones tcdz_chk u_chk (.*);

/* sim/tb_touch_coverage_dead_zones.sv */
// Self-checking testbench for the touch coverage map: directed table, dense-cell run, random phases.
`timescale 1ns / 1ps
module tb_touch_coverage_dead_zones;
  import tcdz_pkg::*;

  localparam logic MODE_POINT = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int CELL_COUNT = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam logic [VIS_W-1:0] COUNT_TOP = '1;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DIRECTED_ROWS = 24;
  localparam int DENSE_TOUCHES = 12;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic             mode;
    logic [PT_W-1:0]  x;
    logic [PT_W-1:0]  y;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } request_t;

  typedef struct packed {
    logic [VIS_W-1:0] visit_count;
    logic [CLS_W-1:0] cover_class;
    logic [NB_W-1:0]  touched_neighbours;
    logic             dead_zone;
    logic [TOT_W-1:0] touched_cells;
    logic [TOT_W-1:0] grid_cells;
  } query_result_t;

  typedef struct packed {
    request_t      req;
    logic          pinned;
    query_result_t answer;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   mode = MODE_POINT;
  logic signed [PT_W-1:0] point_x = '0;
  logic signed [PT_W-1:0] point_y = '0;
  logic [IDX_W-1:0]       cell_col = '0;
  logic [IDX_W-1:0]       cell_row = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [VIS_W-1:0]       visit_count;
  logic [CLS_W-1:0]       cover_class;
  logic [NB_W-1:0]        touched_neighbours;
  logic                   dead_zone;
  logic [TOT_W-1:0]       touched_cells;
  logic [TOT_W-1:0]       grid_cells;

  // typed-in answer travels with the request so the acceptance edge sees it
  logic          answer_pinned = 1'b0;
  query_result_t pinned_answer = '0;

  touch_coverage_dead_zones DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .point_x(point_x),
    .point_y(point_y),
    .cell_col(cell_col),
    .cell_row(cell_row),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .visit_count(visit_count),
    .cover_class(cover_class),
    .touched_neighbours(touched_neighbours),
    .dead_zone(dead_zone),
    .touched_cells(touched_cells),
    .grid_cells(grid_cells)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the coverage map
  logic [VIS_W-1:0] cell_visits [CELL_COUNT];
  logic [TOT_W-1:0] cells_touched;
  int               width_px;
  int               height_px;

  query_result_t pending_answers [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            stall_left = 0;
  bit            calm = 1'b0;
  plan_row_t     directed_plan [DIRECTED_ROWS];

  function automatic int grid_span(input int pixels, input int limit);
    int n;
    n = (pixels + CELL_PIXELS_DEF - 1) / CELL_PIXELS_DEF;
    if (n == 0) n = 1;
    if (n > limit) n = limit;
    return n;
  endfunction

  function automatic int cell_of(input logic signed [PT_W-1:0] p, input int span);
    int c;
    if (p < 0) return 0;
    c = int'(p) / CELL_PIXELS_DEF;
    if (c > span - 1) c = span - 1;
    return c;
  endfunction

  function automatic void record_touch(input logic signed [PT_W-1:0] x,
                                       input logic signed [PT_W-1:0] y);
    int col, row, slot;
    col = cell_of(x, grid_span(width_px, MAX_COLS_DEF));
    row = cell_of(y, grid_span(height_px, MAX_ROWS_DEF));
    slot = row * MAX_COLS_DEF + col;
    if (cell_visits[slot] == 0 && cells_touched != TOTAL_MAX)
      cells_touched = cells_touched + 1'b1;
    if (cell_visits[slot] != COUNT_TOP) cell_visits[slot] = cell_visits[slot] + 1'b1;
  endfunction

  function automatic query_result_t predict_answer(input int col, input int row);
    query_result_t r;
    int cols, rows, v, nb, dx, dy;
    cols = grid_span(width_px, MAX_COLS_DEF);
    rows = grid_span(height_px, MAX_ROWS_DEF);
    r = '0;
    nb = 0;
    if (col < cols && row < rows) begin
      v = int'(cell_visits[row * MAX_COLS_DEF + col]);
      r.visit_count = VIS_W'(v);
      r.cover_class = (v > LIGHT_LIMIT) ? CLS_DENSE : ((v > 0) ? CLS_LIGHT : CLS_NEVER);
      if (col >= 1 && row >= 1 && col + 1 < cols && row + 1 < rows) begin
        for (dy = -1; dy <= 1; dy++)
          for (dx = -1; dx <= 1; dx++)
            if ((dx != 0 || dy != 0) && cell_visits[(row + dy) * MAX_COLS_DEF + col + dx] != 0)
              nb++;
        r.touched_neighbours = NB_W'(nb);
        r.dead_zone = (v == 0 && nb >= DEAD_NEIGHBOURS);
      end
    end
    r.touched_cells = cells_touched;
    r.grid_cells = TOT_W'(cols * rows);
    return r;
  endfunction

  function automatic int idle_burst();
    if (calm || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 13);
  endfunction

  task automatic issue_request(input request_t r, input logic pin,
                               input query_result_t ans, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= r.mode;
    point_x <= r.x;
    point_y <= r.y;
    cell_col <= r.col;
    cell_row <= r.row;
    answer_pinned <= pin;
    pinned_answer <= ans;
    do @(posedge clk); while (!in_ready);
  endtask

  // block must be idle: all answers in, and time for a trailing point request to finish
  task automatic apply_screen(input int w, input int h);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    width_px = w;
    height_px = h;
  endtask

  task automatic run_phase(input int items);
    request_t r;
    int cols, rows, hot_c, hot_r, c, rw, pick;
    cols = grid_span(width_px, MAX_COLS_DEF);
    rows = grid_span(height_px, MAX_ROWS_DEF);
    hot_c = $urandom_range(0, cols > 6 ? cols - 6 : 0);
    hot_r = $urandom_range(0, rows > 6 ? rows - 6 : 0);
    repeat (items) begin
      r.mode = ($urandom_range(0, 9) < 6) ? MODE_POINT : MODE_QUERY;
      r.x = PT_W'($urandom);
      r.y = PT_W'($urandom);
      r.col = IDX_W'($urandom);
      r.row = IDX_W'($urandom);
      pick = $urandom_range(0, 99);
      if (r.mode == MODE_POINT) begin
        if (pick < 70) begin
          // cluster around a mostly-empty hole so dead zones show up
          c = hot_c + $urandom_range(0, 5);
          rw = hot_r + $urandom_range(0, 5);
          if (c == hot_c + 2 && rw == hot_r + 2 && $urandom_range(0, 9) != 0) c = c + 1;
          r.x = PT_W'(c * CELL_PIXELS_DEF + $urandom_range(0, CELL_PIXELS_DEF - 1));
          r.y = PT_W'(rw * CELL_PIXELS_DEF + $urandom_range(0, CELL_PIXELS_DEF - 1));
        end else if (pick < 85) begin
          r.x = PT_W'($urandom_range(0, width_px + CELL_PIXELS_DEF));
          r.y = PT_W'($urandom_range(0, height_px + CELL_PIXELS_DEF));
        end
      end else begin
        if (pick < 20) begin
          r.col = IDX_W'(hot_c + 2);
          r.row = IDX_W'(hot_r + 2);
        end else if (pick < 70) begin
          r.col = IDX_W'(hot_c + $urandom_range(0, 6));
          r.row = IDX_W'(hot_r + $urandom_range(0, 6));
        end else if (pick < 90) begin
          r.col = IDX_W'($urandom_range(0, cols));
          r.row = IDX_W'($urandom_range(0, rows));
        end
      end
      issue_request(r, 1'b0, '0, idle_burst());
    end
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      if (mode == MODE_POINT) record_touch(point_x, point_y);
      else if (answer_pinned) pending_answers.push_back(pinned_answer);
      else pending_answers.push_back(predict_answer(int'(cell_col), int'(cell_row)));
    end
  end

  always @(posedge clk) begin
    query_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t ns: result with no query pending, expected none, actual %0d/%0d/%0d/%0d/%0d/%0d",
                 $time, visit_count, cover_class, touched_neighbours, dead_zone,
                 touched_cells, grid_cells);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        compare_field("visit_count", int'(want.visit_count), int'(visit_count));
        compare_field("cover_class", int'(want.cover_class), int'(cover_class));
        compare_field("touched_neighbours", int'(want.touched_neighbours),
                      int'(touched_neighbours));
        compare_field("dead_zone", int'(want.dead_zone), int'(dead_zone));
        compare_field("touched_cells", int'(want.touched_cells), int'(touched_cells));
        compare_field("grid_cells", int'(want.grid_cells), int'(grid_cells));
      end
    end
  end

  // result side back-pressure: random stalls on out_ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_touch_coverage_dead_zones: FAIL");
      $finish;
    end
  end

  initial begin
    request_t sat_touch;
    request_t sat_query;
    int phase_w [PHASES];
    int phase_h [PHASES];
    for (int i = 0; i < CELL_COUNT; i++) cell_visits[i] = '0;
    cells_touched = '0;
    width_px = WIDTH_RST;
    height_px = HEIGHT_RST;
    // 1x1, capped 64x64, single interior cell, two columns, small, one row, default, 10x10,
    // one column
    phase_w = '{0, 4095, 120, 80, 200, 2560, 1920, 400, 1};
    phase_h = '{0, 4095, 120, 2560, 160, 1, 1200, 400, 4095};

    // default screen gives a 48 x 30 grid of 1440 cells
    directed_plan = '{
      '{'{MODE_QUERY, 13'd0, 13'd0, 6'd0, 6'd0}, 1'b1,
        '{16'd0, CLS_NEVER, 4'd0, 1'b0, 13'd0, 13'd1440}},
      '{'{MODE_QUERY, 13'd0, 13'd0, 6'd63, 6'd63}, 1'b1,
        '{16'd0, CLS_NEVER, 4'd0, 1'b0, 13'd0, 13'd1440}},
      '{'{MODE_QUERY, 13'd0, 13'd0, 6'd47, 6'd29}, 1'b1,
        '{16'd0, CLS_NEVER, 4'd0, 1'b0, 13'd0, 13'd1440}},
      '{'{MODE_QUERY, 13'd0, 13'd0, 6'd1, 6'd1}, 1'b1,
        '{16'd0, CLS_NEVER, 4'd0, 1'b0, 13'd0, 13'd1440}},
      // most negative coordinates clamp to cell 0
      '{'{MODE_POINT, 13'h1000, 13'h1000, 6'd63, 6'd63}, 1'b0, '0},
      // far past the screen clamps to the last column and row
      '{'{MODE_POINT, 13'h0FFF, 13'h0FFF, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'h1FFF, 13'h0FFF, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd39, 13'd39, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd40, 13'd40, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_QUERY, 13'd0, 13'd0, 6'd0, 6'd0}, 1'b1,
        '{16'd2, CLS_LIGHT, 4'd0, 1'b0, 13'd4, 13'd1440}},
      // six touched neighbours around an empty cell
      '{'{MODE_POINT, 13'd180, 13'd180, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd220, 13'd180, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd260, 13'd180, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd180, 13'd220, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd260, 13'd220, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd180, 13'd260, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_QUERY, 13'd0, 13'd0, 6'd5, 6'd5}, 1'b0, '0},
      '{'{MODE_POINT, 13'd40, 13'd79, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd79, 13'd40, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd41, 13'd41, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd79, 13'd79, 6'd0, 6'd0}, 1'b0, '0},
      '{'{MODE_QUERY, 13'd0, 13'd0, 6'd1, 6'd1}, 1'b0, '0},
      '{'{MODE_QUERY, 13'd0, 13'd0, 6'd47, 6'd0}, 1'b0, '0},
      '{'{MODE_POINT, 13'd1919, 13'd1199, 6'd0, 6'd0}, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    calm = 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++)
      issue_request(directed_plan[i].req, directed_plan[i].pinned, directed_plan[i].answer,
                    idle_burst());

    // pile touches onto the far corner cell of a capped grid until it reads dense
    apply_screen(4095, 4095);
    calm = 1'b1;
    sat_touch = '{MODE_POINT, 13'h0FFF, 13'h0FFF, 6'd0, 6'd0};
    repeat (DENSE_TOUCHES) issue_request(sat_touch, 1'b0, '0, 0);
    sat_query = '{MODE_QUERY, 13'h1555, 13'h0AAA, 6'd63, 6'd63};
    issue_request(sat_query, 1'b0, '0, 0);

    for (int p = 0; p < PHASES; p++) begin
      apply_screen(phase_w[p], phase_h[p]);
      calm = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
      run_phase(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_touch_coverage_dead_zones: PASS");
    end else begin
      $display("tb_touch_coverage_dead_zones: FAIL");
    end
    $finish;
  end

endmodule
